// ----- rtl/core/pal_pkg.sv -----
// pal_pkg: shared constants for the positional array list core
// operation codes, field widths and default store capacity; no dependencies
package pal_pkg;

  localparam int DEF_CAPACITY = 32;

  localparam int OP_W  = 2;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int LEN_W = 6;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_GET    = 2'd2;

endpackage

// ----- rtl/core/positional_array_list_core.sv -----
// positional_array_list_core: ordered list of signed 32-bit elements in a 1r1w store
// depends on pal_pkg for operation codes and field widths
// usage
//   in_valid/in_stall carry one request: in_operation (insert, delete, get),
//   in_position (1-based) and in_item_value (used by insert only). a request
//   is taken when in_valid is high and in_stall is low.
//   out_valid/out_stall carry one result per request: out_ok, out_read_value
//   (element removed or read, zero on insert or error) and out_list_length.
// timing
//   one request is worked on at a time; in_stall is high until it is finished.
//   the store has one write and one registered read port, and every entry
//   that moves is read and then written back through those ports. an insert
//   shifts the entries from the position on up by one, from the end down,
//   then writes the new item; a delete or get first reads the entry at the
//   position, and a delete then moves every later entry down by one.
// reset: rst_n low empties the list and drops any pending result; the store
//   itself is not cleared, entries beyond the length are never read.
// stall: a result holds in the output register while out_stall is high; a new
//   request may be taken meanwhile but its result waits until the slot frees.
module positional_array_list_core #(
  parameter int CAPACITY = pal_pkg::DEF_CAPACITY
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pal_pkg::OP_W-1:0]        in_operation,
  input  logic [pal_pkg::POS_W-1:0]       in_position,
  input  logic signed [pal_pkg::VAL_W-1:0] in_item_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_ok,
  output logic signed [pal_pkg::VAL_W-1:0] out_read_value,
  output logic [pal_pkg::LEN_W-1:0]       out_list_length
);
  import pal_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_SWR  = 9'b000000100,
    S_INS  = 9'b000001000,
    S_GRD  = 9'b000010000,
    S_GOT  = 9'b000100000,
    S_DRD  = 9'b001000000,
    S_DWR  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic             wr_en;

  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    k_r, k_nxt;
  logic [AW-1:0]    tgt_r, tgt_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             ok_r, ok_nxt;
  logic [VAL_W-1:0] got_r, got_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [VAL_W-1:0] out_val_r, out_val_nxt;
  logic [LEN_W-1:0] out_len_r, out_len_nxt;

  logic [CMPW-1:0]  pos_ext;
  logic [CMPW-1:0]  cnt_ext;
  logic [AW-1:0]    pos_idx;
  logic             out_free;
  logic             accept;

  assign pos_ext  = CMPW'(in_position);
  assign cnt_ext  = CMPW'(count_r);
  assign pos_idx  = AW'(pos_ext - CMPW'(1));
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    tgt_nxt       = tgt_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    ok_nxt        = ok_r;
    got_nxt       = got_r;
    rd_addr       = k_r;
    wr_addr       = k_r;
    wr_data       = rd_data_r;
    wr_en         = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_val_nxt   = out_val_r;
    out_len_nxt   = out_len_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = in_operation;
          val_nxt = in_item_value;
          tgt_nxt = pos_idx;
          got_nxt = '0;
          ok_nxt  = 1'b0;
          state_nxt = S_DONE;
          unique case (in_operation) inside
            OP_INSERT: begin
              if ((count_r < CW'(CAPACITY)) && (pos_ext != '0) &&
                  (pos_ext <= cnt_ext + CMPW'(1))) begin
                ok_nxt = 1'b1;
                k_nxt  = AW'(count_r);
                state_nxt = (AW'(count_r) == pos_idx) ? S_INS : S_RD;
              end
            end
            OP_DELETE, OP_GET: begin
              if ((pos_ext != '0) && (pos_ext <= cnt_ext)) begin
                ok_nxt    = 1'b1;
                state_nxt = S_GRD;
              end
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end
      S_RD: begin
        rd_addr   = k_r - AW'(1);
        state_nxt = S_SWR;
      end
      S_SWR: begin
        wr_en   = 1'b1;
        wr_addr = k_r;
        wr_data = rd_data_r;
        k_nxt   = k_r - AW'(1);
        state_nxt = ((k_r - AW'(1)) == tgt_r) ? S_INS : S_RD;
      end
      S_INS: begin
        wr_en     = 1'b1;
        wr_addr   = tgt_r;
        wr_data   = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_GRD: begin
        rd_addr   = tgt_r;
        state_nxt = S_GOT;
      end
      S_GOT: begin
        got_nxt = rd_data_r;
        if (op_r == OP_GET) begin
          state_nxt = S_DONE;
        end else if (CW'(tgt_r) + CW'(1) == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          k_nxt     = tgt_r + AW'(1);
          state_nxt = S_DRD;
        end
      end
      S_DRD: begin
        rd_addr   = k_r;
        state_nxt = S_DWR;
      end
      S_DWR: begin
        wr_en   = 1'b1;
        wr_addr = k_r - AW'(1);
        wr_data = rd_data_r;
        if (CW'(k_r) + CW'(1) == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = S_DRD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_val_nxt   = got_r;
          out_len_nxt   = LEN_W'(count_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    tgt_r     <= tgt_nxt;
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    ok_r      <= ok_nxt;
    got_r     <= got_nxt;
    out_ok_r  <= out_ok_nxt;
    out_val_r <= out_val_nxt;
    out_len_r <= out_len_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_read_value  = out_val_r;
  assign out_list_length = out_len_r;

endmodule
